// File: src/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// shared types and constants of the transport stream pid demultiplexer
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int unsigned PACKET_BYTES   = 188;
  localparam int unsigned TABLE_ENTRIES  = 16;
  localparam int unsigned POS_W          = $clog2(PACKET_BYTES);
  localparam int unsigned IDX_W          = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned USED_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned PID_W          = 13;
  localparam int unsigned SIDX_W         = 4;
  localparam int unsigned MAX_RESULTS    = 3;
  localparam int unsigned FIFO_DEPTH     = 8;
  localparam int unsigned FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0]       SYNC_BYTE      = 8'h47;
  localparam logic [PID_W-1:0] VIDEO_PID_RST  = 13'h100;
  localparam logic [7:0]       UNIT_START_BIT = 8'h40;
  localparam logic [7:0]       ADAPT_BIT      = 8'h20;

  // one result item
  typedef struct packed {
    logic [7:0]        out_byte;
    logic [SIDX_W-1:0] stream_index;
    logic [PID_W-1:0]  stream_pid;
    logic              new_stream;
    logic              video_payload;
    logic              unit_boundary;
    logic              table_full;
    logic              last;
  } res_t;

  // results produced by one input item, slot 0 first
  typedef struct packed {
    logic [1:0]                 count;
    res_t [MAX_RESULTS-1:0]     res;
  } push_t;

endpackage

// File: src/tsd_parser.sv
// ----------------------------------------------------------------------------
// tsd_parser
// packet position tracking, pid table lookup and result generation
// ----------------------------------------------------------------------------
module tsd_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  logic [7:0]                ts_byte,
  input  logic                      video_pid_we,
  input  logic [tsd_pkg::PID_W-1:0] video_pid,
  output tsd_pkg::push_t            push
);

  logic [tsd_pkg::PID_W-1:0]  pid_table [tsd_pkg::TABLE_ENTRIES];
  logic [tsd_pkg::PID_W-1:0]  video_pid_reg;
  logic [tsd_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic                       packet_accepted, packet_accepted_next;
  logic [7:0]                 header_high_byte, header_high_byte_next;
  logic [tsd_pkg::USED_W-1:0] entries_used, entries_used_next;
  logic [tsd_pkg::IDX_W-1:0]  current_index, current_index_next;
  logic [tsd_pkg::PID_W-1:0]  current_pid, current_pid_next;
  logic [7:0]                 adaptation_skip, adaptation_skip_next;
  logic                       length_byte_next, length_byte_next_next;

  logic [tsd_pkg::POS_W-1:0]  pos;
  logic [tsd_pkg::PID_W-1:0]  pid;
  logic                       found;
  logic [tsd_pkg::IDX_W-1:0]  found_idx;
  logic [tsd_pkg::IDX_W-1:0]  idx;
  logic                       table_we;
  logic                       fresh;
  logic                       unit;
  logic                       payload;

  assign pos = (byte_position >= tsd_pkg::POS_W'(tsd_pkg::PACKET_BYTES)) ? '0 : byte_position;
  assign pid = {header_high_byte[tsd_pkg::PID_W-9:0], ts_byte};

  // parallel compare against the entries in use, lowest hit wins
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = tsd_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if ((tsd_pkg::USED_W'(i) < entries_used) && (pid_table[i] == pid)) begin
        found     = 1'b1;
        found_idx = tsd_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    byte_position_next    = (pos == tsd_pkg::POS_W'(tsd_pkg::PACKET_BYTES - 1)) ? '0 : pos + 1'b1;
    packet_accepted_next  = packet_accepted;
    header_high_byte_next = header_high_byte;
    entries_used_next     = entries_used;
    current_index_next    = current_index;
    current_pid_next      = current_pid;
    adaptation_skip_next  = adaptation_skip;
    length_byte_next_next = length_byte_next;
    table_we              = 1'b0;
    fresh                 = 1'b0;
    unit                  = 1'b0;
    payload               = 1'b0;
    idx                   = found ? found_idx : entries_used[tsd_pkg::IDX_W-1:0];
    push                  = '0;

    if (pos == '0) begin
      packet_accepted_next  = (ts_byte == tsd_pkg::SYNC_BYTE);
      length_byte_next_next = 1'b0;
      adaptation_skip_next  = '0;
    end else if (pos == tsd_pkg::POS_W'(1)) begin
      if (packet_accepted) begin
        header_high_byte_next = ts_byte;
      end
    end else if (pos == tsd_pkg::POS_W'(2)) begin
      if (packet_accepted) begin
        current_pid_next = pid;
        if (!found && (entries_used == tsd_pkg::USED_W'(tsd_pkg::TABLE_ENTRIES))) begin
          // no free entry: flag and drop the rest of the packet
          packet_accepted_next           = 1'b0;
          push.count                     = 2'd1;
          push.res[0].out_byte           = ts_byte;
          push.res[0].stream_pid         = pid;
          push.res[0].table_full         = 1'b1;
          push.res[0].last               = 1'b1;
        end else begin
          if (!found) begin
            table_we          = 1'b1;
            fresh             = 1'b1;
            entries_used_next = entries_used + 1'b1;
          end
          unit = (pid == video_pid_reg) && ((header_high_byte & tsd_pkg::UNIT_START_BIT) != '0);
          current_index_next = idx;
          push.count = 2'd3;
          for (int k = 0; k < tsd_pkg::MAX_RESULTS; k++) begin
            push.res[k].stream_index = tsd_pkg::SIDX_W'(idx);
            push.res[k].stream_pid   = pid;
            push.res[k].new_stream   = fresh;
          end
          push.res[0].out_byte      = tsd_pkg::SYNC_BYTE;
          push.res[0].unit_boundary = unit;
          push.res[1].out_byte      = header_high_byte;
          push.res[2].out_byte      = ts_byte;
          push.res[2].last          = 1'b1;
        end
      end
    end else if (packet_accepted) begin
      if (current_pid == video_pid_reg) begin
        if (pos == tsd_pkg::POS_W'(3)) begin
          length_byte_next_next = (ts_byte & tsd_pkg::ADAPT_BIT) != '0;
          adaptation_skip_next  = '0;
        end else if (length_byte_next) begin
          adaptation_skip_next  = ts_byte;
          length_byte_next_next = 1'b0;
        end else if (adaptation_skip == '0) begin
          payload = 1'b1;
        end else begin
          adaptation_skip_next = adaptation_skip - 1'b1;
        end
      end
      push.count                 = 2'd1;
      push.res[0].out_byte       = ts_byte;
      push.res[0].stream_index   = tsd_pkg::SIDX_W'(current_index);
      push.res[0].stream_pid     = current_pid;
      push.res[0].video_payload  = payload;
      push.res[0].last           = 1'b1;
    end

    if (!fire) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      video_pid_reg    <= tsd_pkg::VIDEO_PID_RST;
      byte_position    <= '0;
      packet_accepted  <= 1'b0;
      header_high_byte <= '0;
      entries_used     <= '0;
      current_index    <= '0;
      current_pid      <= '0;
      adaptation_skip  <= '0;
      length_byte_next <= 1'b0;
    end else begin
      if (video_pid_we) begin
        video_pid_reg <= video_pid;
      end
      if (fire) begin
        byte_position    <= byte_position_next;
        packet_accepted  <= packet_accepted_next;
        header_high_byte <= header_high_byte_next;
        entries_used     <= entries_used_next;
        current_index    <= current_index_next;
        current_pid      <= current_pid_next;
        adaptation_skip  <= adaptation_skip_next;
        length_byte_next <= length_byte_next_next;
      end
    end
  end

  // table entries are read only below the fill count, so no reset
  always_ff @(posedge clk) begin
    if (fire && table_we) begin
      pid_table[entries_used[tsd_pkg::IDX_W-1:0]] <= pid;
    end
  end

endmodule

// File: src/tsd_fifo.sv
// ----------------------------------------------------------------------------
// tsd_fifo
// result queue taking up to three items per cycle and releasing one
// ----------------------------------------------------------------------------
module tsd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  tsd_pkg::push_t push,
  input  logic           pop,
  output logic           not_empty,
  output logic           room,
  output tsd_pkg::res_t  head
);

  tsd_pkg::res_t                  mem [tsd_pkg::FIFO_DEPTH];
  logic [tsd_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [tsd_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [tsd_pkg::FIFO_CNT_W-1:0] count;
  logic                           do_pop;

  assign not_empty = (count != '0);
  assign room      = (count <= tsd_pkg::FIFO_CNT_W'(tsd_pkg::FIFO_DEPTH - tsd_pkg::MAX_RESULTS));
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tsd_pkg::FIFO_PTR_W'(push.count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + tsd_pkg::FIFO_CNT_W'(push.count) - tsd_pkg::FIFO_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < tsd_pkg::MAX_RESULTS; k++) begin
      if (tsd_pkg::FIFO_CNT_W'(k) < tsd_pkg::FIFO_CNT_W'(push.count)) begin
        mem[wr_ptr + tsd_pkg::FIFO_PTR_W'(k)] <= push.res[k];
      end
    end
  end

endmodule

// File: src/transport_stream_pid_demux_top.sv
// ----------------------------------------------------------------------------
// transport_stream_pid_demux_top
// pid demultiplexer for a byte-wide transport stream
// ----------------------------------------------------------------------------
// an accepted byte is held in the input register, then its results in the queue
// throughput: one byte per cycle sustained; results leave one per cycle, the
//   three header results of byte 2 fill the slots that bytes 0 and 1 leave free
// the input stalls only while the result queue lacks room for three results
// reset: synchronous, clears position, table fill count, queue and video_pid
//   (back to 0x100); pid table contents are not cleared
module transport_stream_pid_demux_top (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              ts_valid,
  output logic                              ts_stall,
  input  logic [7:0]                        ts_byte,
  // configuration
  input  logic                              video_pid_we,
  input  logic [tsd_pkg::PID_W-1:0]         video_pid,
  // result channel
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic [7:0]                        out_byte,
  output logic [tsd_pkg::SIDX_W-1:0]        stream_index,
  output logic [tsd_pkg::PID_W-1:0]         stream_pid,
  output logic                              new_stream,
  output logic                              video_payload,
  output logic                              unit_boundary,
  output logic                              table_full,
  output logic                              last
);

  // input register
  logic          in_valid;
  logic [7:0]    in_byte;
  logic          fire;
  logic          room;
  tsd_pkg::push_t push;
  tsd_pkg::res_t  head;

  // the registered byte is processed once the queue can take all its results
  assign fire     = in_valid && room;
  assign ts_stall = in_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!ts_stall) begin
      in_valid <= ts_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (ts_valid && !ts_stall) begin
      in_byte <= ts_byte;
    end
  end

  // header parsing, pid lookup and per-byte marking
  tsd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .ts_byte      (in_byte),
    .video_pid_we (video_pid_we),
    .video_pid    (video_pid),
    .push         (push)
  );

  // result queue, also the output register toward the consumer
  tsd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (!res_stall),
    .not_empty (res_valid),
    .room      (room),
    .head      (head)
  );

  assign out_byte      = head.out_byte;
  assign stream_index  = head.stream_index;
  assign stream_pid    = head.stream_pid;
  assign new_stream    = head.new_stream;
  assign video_payload = head.video_payload;
  assign unit_boundary = head.unit_boundary;
  assign table_full    = head.table_full;
  assign last          = head.last;

endmodule

// File: src/tsd_checker.sv
// ----------------------------------------------------------------------------
// tsd_checker
// port-level checks of the demultiplexer, bound to the top level
// ----------------------------------------------------------------------------
module tsd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       ts_stall,
  input logic                       res_valid,
  input logic                       res_stall,
  input logic [7:0]                 out_byte,
  input logic [tsd_pkg::PID_W-1:0]  stream_pid,
  input logic                       new_stream,
  input logic                       unit_boundary,
  input logic                       last
);

  // a stalled result item holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(stream_pid))
    else $error("stalled result changed");

  // reset empties the queue and frees the input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid && !ts_stall)
    else $error("queue not cleared by reset");

  // header results are queued together, so a unit boundary is followed at once
  a_unit_follow: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && unit_boundary |=> res_valid && !last)
    else $error("header results of a unit start not back to back");

  // new-stream header results arrive without gaps
  a_new_follow: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && new_stream && !last |=> res_valid && new_stream)
    else $error("new stream header results broken up");

endmodule

bind transport_stream_pid_demux_top tsd_checker u_tsd_checker (
  .clk           (clk),
  .rst           (rst),
  .ts_stall      (ts_stall),
  .res_valid     (res_valid),
  .res_stall     (res_stall),
  .out_byte      (out_byte),
  .stream_pid    (stream_pid),
  .new_stream    (new_stream),
  .unit_boundary (unit_boundary),
  .last          (last)
);
